// ===== hdl/mfb_pkg.sv =====
// shared types, constants and build-time functions for the mel filterbank accumulator
// the band edge and per-bin weight rom is worked out here during elaboration
// no dependencies
`timescale 1ns / 1ps

package mfb_pkg;

  // default build parameters
  localparam int BANDS_DEF       = 40;
  localparam int FFT_SIZE_DEF    = 512;
  localparam int SAMPLE_RATE_DEF = 16000;
  localparam int MIN_FREQ_DEF    = 133;
  localparam int MAX_FREQ_DEF    = 6855;
  localparam int POWER_BITS_DEF  = 32;

  // fixed field widths
  localparam int POWER_W     = 32;
  localparam int ACC_W       = 48;
  localparam int BAND_IDX_W  = 6;   // band index field, up to 64 bands
  localparam int BAND_FW     = 7;   // rom band field, holds 0 .. 64
  localparam int WEIGHT_W    = 17;  // q1.16 weight, 65536 is one
  localparam int BIN_W       = 10;  // bin counter
  localparam int ROM_DEPTH   = 1 << BIN_W;
  localparam int MAX_EDGES   = 66;  // up to 64 bands plus two outer edges
  localparam int PROD_W      = POWER_W + WEIGHT_W;

  localparam logic [63:0] Q30 = 64'd1 << 30;

  typedef struct packed {
    logic                  add_lo;  // bin feeds band k (rising slope)
    logic                  add_hi;  // bin feeds band k-1 (falling slope)
    logic [BAND_FW-1:0]    band;    // k
    logic [WEIGHT_W-1:0]   weight;  // weight of band k, band k-1 gets one minus it
  } rom_entry_t;

  typedef rom_entry_t [ROM_DEPTH-1:0] rom_t;
  typedef logic [MAX_EDGES-1:0][63:0] edge_arr_t;
  typedef logic [32:0][63:0]          root_arr_t;

  // accumulator bank request
  typedef struct packed {
    logic [BAND_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [BAND_IDX_W-1:0] wr_addr;
    logic [ACC_W-1:0]      wr_data;
    logic                  clear;
  } acc_req_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bq;
    logic [63:0] x;
    r  = '0;
    bq = 64'd1 << 62;
    x  = v;
    for (int i = 0; i < 32; i++) begin
      if (bq > x) bq = bq >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bq != 0) begin
        if (x >= r + bq) begin
          x = x - (r + bq);
          r = (r >> 1) + bq;
        end else begin
          r = r >> 1;
        end
        bq = bq >> 2;
      end
    end
    return r;
  endfunction

  // log2(a/b) in q32, a > b > 0
  function automatic logic [63:0] log2_ratio_q32(logic [63:0] a, logic [63:0] b);
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] frac;
    y    = udiv64(a << 30, b);
    n    = '0;
    frac = '0;
    for (int i = 0; i < 8; i++) begin
      if (y >= 2 * Q30) begin
        y = y >> 1;
        n = n + 64'd1;
      end
    end
    for (int i = 0; i < 32; i++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 2 * Q30) begin
        y    = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return (n << 32) | frac;
  endfunction

  // 2^(f / 2^32) in q30
  function automatic logic [63:0] exp2_frac_q30(logic [31:0] f, root_arr_t r2);
    logic [63:0] m;
    m = Q30;
    for (int i = 1; i <= 32; i++) begin
      if (f[32-i]) m = (m * r2[i]) >> 30;
    end
    return m;
  endfunction

  function automatic edge_arr_t build_edges(logic [63:0] bands, logic [63:0] fft,
                                            logic [63:0] sr, logic [63:0] fmin,
                                            logic [63:0] fmax);
    edge_arr_t   e;
    root_arr_t   r2;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] l2;
    logic [63:0] x;
    logic [63:0] m;
    logic [63:0] hz;
    e = '0;
    if (fmax <= fmin) return e;
    a     = 64'd700 + fmin;
    b     = 64'd700 + fmax;
    r2    = '0;
    r2[0] = 2 * Q30;
    for (int i = 1; i <= 32; i++) r2[i] = isqrt64(r2[i-1] << 30);
    l2 = log2_ratio_q32(b, a);
    for (int k = 0; k < MAX_EDGES; k++) begin
      if (64'(k) <= bands + 64'd1) begin
        x    = udiv64(64'(k) * l2, bands + 64'd1);
        m    = exp2_frac_q30(x[31:0], r2);
        hz   = ((a * m) << (x >> 32)) - 64'd700 * Q30;
        e[k] = udiv64(hz * fft + (sr << 29), sr << 30);
        if (k > 0 && e[k] < e[k-1]) e[k] = e[k-1];
      end
    end
    return e;
  endfunction

  // per-bin band and weight table, bins at or past fft size stay empty
  function automatic rom_t build_rom(logic [63:0] bands, logic [63:0] fft,
                                     logic [63:0] sr, logic [63:0] fmin,
                                     logic [63:0] fmax);
    rom_t        r;
    edge_arr_t   e;
    logic [63:0] jj;
    logic [63:0] d;
    logic [63:0] w;
    int          kk;
    logic        ok;
    r = '0;
    e = build_edges(bands, fft, sr, fmin, fmax);
    for (int j = 0; j < ROM_DEPTH; j++) begin
      jj = 64'(j);
      if (fmax > fmin && jj < fft) begin
        kk = -1;
        for (int i = 0; i < MAX_EDGES - 1; i++) begin
          if (64'(i) <= bands && e[i] <= jj) kk = i;
        end
        if (kk >= 0) begin
          d  = e[kk+1] - e[kk];
          ok = 1'b1;
          if (64'(kk) == bands && jj >= e[kk+1]) begin
            // on the last edge when the outer edges coincide
            if (jj != e[kk]) ok = 1'b0;
            w = '0;
          end else if (d == 0) begin
            w = '0;
          end else begin
            w = udiv64(((jj - e[kk]) << 16) + (d >> 1), d);
          end
          if (ok) begin
            r[j].add_lo = (64'(kk) < bands);
            r[j].add_hi = (kk >= 1);
            r[j].band   = BAND_FW'(kk);
            r[j].weight = WEIGHT_W'(w);
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/mfb_acc_bank.sv =====
// band accumulator memory with per-entry valid bits and registered read
// unwritten or cleared entries read as zero; uses mfb_pkg
`timescale 1ns / 1ps

module mfb_acc_bank
  import mfb_pkg::*;
#(
  parameter int BANDS = BANDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  acc_req_t         req,
  output logic [ACC_W-1:0] rd_data
);

  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

  logic [ACC_W-1:0] mem [BANDS];
  logic [BANDS-1:0] valid;
  logic [ACC_W-1:0] rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[BW-1:0]] <= req.wr_data;
    end
    rd_q <= mem[req.rd_addr[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[req.rd_addr[BW-1:0]];
      if (req.clear) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr[BW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== hdl/mel_filterbank_accumulator.sv =====
// a bin steps through mul_lo, add_lo and add_hi before ready returns; a last bin is
// followed by the frame's bands, each read (emit_rd) and then handed to the output
// register (emit_out), which waits while the output is stalled, with ready back after
// the last band. reset clears state, bin counter and accumulators at once (valid bits),
// no clearing pass. uses mfb_pkg, mfb_acc_bank
`timescale 1ns / 1ps

module mel_filterbank_accumulator
  import mfb_pkg::*;
#(
  parameter int BANDS       = BANDS_DEF,
  parameter int FFT_SIZE    = FFT_SIZE_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int MIN_FREQ_HZ = MIN_FREQ_DEF,
  parameter int MAX_FREQ_HZ = MAX_FREQ_DEF,
  parameter int POWER_BITS  = POWER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // bin stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [POWER_W-1:0]    s_tdata,   // [31:0] power
  input  logic                  s_tlast,   // last bin of the frame
  // band stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [ACC_W-1:0]      m_tdata,   // [47:0] band_energy
  output logic [BAND_IDX_W-1:0] m_tuser,   // [5:0] band_index
  output logic                  m_tlast    // last band of the frame
);

  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

  // only the low POWER_BITS of the power word take part
  localparam logic [POWER_W-1:0] POWER_MASK =
    (POWER_BITS >= POWER_W) ? {POWER_W{1'b1}} : POWER_W'((64'd1 << POWER_BITS) - 64'd1);

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);
  localparam logic [BW-1:0]       LAST_IDX = BW'(BANDS - 1);

  // band and weight for every bin index, built at elaboration
  localparam rom_t BIN_ROM = build_rom(64'(BANDS), 64'(FFT_SIZE), 64'(SAMPLE_RATE),
                                       64'(MIN_FREQ_HZ), 64'(MAX_FREQ_HZ));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,    // multiply by band k weight, read band k
    S_ADD_LO,    // add into band k, multiply by band k-1 weight, read band k-1
    S_ADD_HI,    // add into band k-1
    S_EMIT_RD,   // read band for output
    S_EMIT_OUT   // hand band to output register
  } state_t;

  state_t              state;
  logic [BIN_W-1:0]    bin_count;
  logic [POWER_W-1:0]  power_q;
  logic                last_q;
  rom_entry_t          rom_q;
  logic [PROD_W-1:0]   prod;
  logic [BW-1:0]       idx;

  acc_req_t            acc_req;
  logic [ACC_W-1:0]    acc_rd;
  logic [ACC_W:0]      sum;
  logic [BAND_FW-1:0]  band_hi;
  logic [WEIGHT_W-1:0] mul_w;
  logic                s_beat;
  logic                out_free;
  logic                emit_load;

  assign s_tready  = (state == S_IDLE);
  assign s_beat    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit_load = (state == S_EMIT_OUT) && out_free;
  assign band_hi   = rom_q.band - BAND_FW'(1);

  // the one multiplier: band k weight first, then its complement for band k-1
  assign mul_w = (state == S_MUL_LO) ? rom_q.weight : ONE_Q16 - rom_q.weight;

  // saturating add of the scaled contribution, floor(p*w/65536)
  assign sum = {1'b0, acc_rd} + (ACC_W + 1)'(prod[PROD_W-1:16]);

  always_comb begin
    acc_req         = '0;
    acc_req.wr_data = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    case (state)
      S_MUL_LO: begin
        if (rom_q.add_lo) acc_req.rd_addr = rom_q.band[BAND_IDX_W-1:0];
      end
      S_ADD_LO: begin
        if (rom_q.add_hi) acc_req.rd_addr = band_hi[BAND_IDX_W-1:0];
        acc_req.wr_en   = rom_q.add_lo;
        acc_req.wr_addr = rom_q.band[BAND_IDX_W-1:0];
      end
      S_ADD_HI: begin
        acc_req.wr_en   = rom_q.add_hi;
        acc_req.wr_addr = band_hi[BAND_IDX_W-1:0];
      end
      S_EMIT_RD, S_EMIT_OUT: begin
        acc_req.rd_addr = BAND_IDX_W'(idx);
        // frame done once the final band moves to the output register
        acc_req.clear   = emit_load && (idx == LAST_IDX);
      end
      default: ;
    endcase
  end

  mfb_acc_bank #(
    .BANDS (BANDS)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .req     (acc_req),
    .rd_data (acc_rd)
  );

  // payload registers: bin word, rom lookup and product
  always_ff @(posedge clk) begin
    if (s_beat) begin
      power_q <= s_tdata & POWER_MASK;
      last_q  <= s_tlast;
      rom_q   <= BIN_ROM[bin_count];
    end
    if (state == S_MUL_LO || state == S_ADD_LO) begin
      prod <= PROD_W'(power_q) * PROD_W'(mul_w);
    end
  end

  // sequencer, bin counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_count <= '0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tuser   <= '0;
      m_tlast   <= 1'b0;
    end else begin
      // a new band beat loads, otherwise the held one drops once taken
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_beat) begin
            // the counter sticks at its top value on a run with no last bin
            if (s_tlast) begin
              bin_count <= '0;
            end else if (bin_count != {BIN_W{1'b1}}) begin
              bin_count <= bin_count + BIN_W'(1);
            end
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: state <= S_ADD_LO;
        S_ADD_LO: state <= S_ADD_HI;
        S_ADD_HI: begin
          idx   <= '0;
          state <= last_q ? S_EMIT_RD : S_IDLE;
        end
        S_EMIT_RD: state <= S_EMIT_OUT;
        S_EMIT_OUT: begin
          if (out_free) begin
            m_tdata  <= acc_rd;
            m_tuser  <= BAND_IDX_W'(idx);
            m_tlast  <= (idx == LAST_IDX);
            if (idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + BW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_mel_filterbank_accumulator.sv =====
// self-checking bench for the mel filterbank accumulator: bin beats in, band energies out
// a local model of the triangular filterbank predicts every band beat; uses mfb_pkg and
// the rtl under hdl/
`timescale 1ns / 1ps

module tb_mel_filterbank_accumulator;
  import mfb_pkg::*;

  localparam int NB    = BANDS_DEF;
  localparam int FFT   = FFT_SIZE_DEF;
  localparam int SR    = SAMPLE_RATE_DEF;
  localparam int FMIN  = MIN_FREQ_DEF;
  localparam int FMAX  = MAX_FREQ_DEF;
  localparam int PBITS = POWER_BITS_DEF;

  typedef bit [63:0] wide_t;

  localparam wide_t ENERGY_CAP = (64'd1 << ACC_W) - 64'd1;
  localparam wide_t POWER_MASK = (64'd1 << PBITS) - 64'd1;
  localparam wide_t UNITY_Q16  = 64'd65536;
  localparam int unsigned BIN_CAP = (1 << BIN_W) - 1;

  localparam int OPENING_ROWS = 16;
  localparam int RANDOM_BINS  = 454;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [ACC_W-1:0]      energy;
    logic [BAND_IDX_W-1:0] band;
    logic                  last_band;
  } band_beat_t;

  // one row of the opening stimulus; all_zero marks frames whose energies are known zero
  typedef struct {
    logic [POWER_W-1:0] power;
    bit                 last;
    bit                 all_zero;
  } bin_row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [POWER_W-1:0]    s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [ACC_W-1:0]      m_tdata;
  logic [BAND_IDX_W-1:0] m_tuser;
  logic                  m_tlast;

  // filterbank model state
  wide_t        mel_edge [NB+2];
  bit           edges_ok;
  wide_t        root_chain [33];
  wide_t        band_sum [NB];
  int unsigned  bin_pos;

  band_beat_t   band_q [$];       // band beats still owed by the block
  int unsigned  mismatches = 0;
  int unsigned  bins_sent  = 0;
  int unsigned  stall_cycles = 0;
  bit           quiet = 1'b0;     // no idling on either side while set
  bin_row_t     opening_bins [OPENING_ROWS];

  mel_filterbank_accumulator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- edge table

  // bit-by-bit floor square root
  function automatic wide_t floor_sqrt(wide_t v);
    wide_t r;
    wide_t t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // log2(num/den) in q32 by repeated squaring of the q30 ratio
  function automatic wide_t log2_q32(wide_t num, wide_t den);
    wide_t y;
    wide_t whole;
    wide_t frac;
    y     = (num << 30) / den;
    whole = '0;
    frac  = '0;
    while (y >= 2 * Q30) begin
      y     = y >> 1;
      whole = whole + 64'd1;
    end
    for (int i = 0; i < 32; i++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 2 * Q30) begin
        y    = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return (whole << 32) | frac;
  endfunction

  // 2^(f/2^32) in q30 from the chain of square roots of two
  function automatic wide_t pow2_frac(bit [31:0] f);
    wide_t m;
    m = Q30;
    for (int i = 1; i <= 32; i++) begin
      if (f[32-i]) m = (m * root_chain[i]) >> 30;
    end
    return m;
  endfunction

  // band edges evenly spaced in mel, each rounded half up to a bin index
  function automatic void derive_edges();
    wide_t a;
    wide_t b;
    wide_t span;
    wide_t x;
    wide_t m;
    wide_t hz;
    a = 64'd700 + wide_t'(FMIN);
    b = 64'd700 + wide_t'(FMAX);
    root_chain[0] = 2 * Q30;
    for (int i = 1; i <= 32; i++) root_chain[i] = floor_sqrt(root_chain[i-1] << 30);
    edges_ok = FMAX > FMIN;
    for (int k = 0; k < NB + 2; k++) mel_edge[k] = '0;
    if (!edges_ok) return;
    span = log2_q32(b, a);
    for (int k = 0; k < NB + 2; k++) begin
      x  = (wide_t'(k) * span) / wide_t'(NB + 1);
      m  = pow2_frac(x[31:0]);
      hz = ((a * m) << x[63:32]) - 64'd700 * Q30;
      mel_edge[k] = (hz * wide_t'(FFT) + (wide_t'(SR) << 29)) / (wide_t'(SR) << 30);
      if (k > 0 && mel_edge[k] < mel_edge[k-1]) mel_edge[k] = mel_edge[k-1];
    end
  endfunction

  // ------------------------------------------------------------ band energies

  function automatic wide_t weighted(wide_t p, wide_t w);
    return (p >> 16) * w + (((p & 64'hFFFF) * w) >> 16);
  endfunction

  function automatic void add_capped(int band, wide_t c);
    if (c > ENERGY_CAP - band_sum[band]) band_sum[band] = ENERGY_CAP;
    else band_sum[band] = band_sum[band] + c;
  endfunction

  // share one bin between the rising slope of band k and the falling slope of band k-1
  function automatic void spread_bin(wide_t p, int unsigned j);
    int    k;
    wide_t jj;
    wide_t d;
    wide_t w;
    jj = wide_t'(j);
    if (!edges_ok || jj >= wide_t'(FFT)) return;
    k = -1;
    for (int i = 0; i <= NB; i++) begin
      if (mel_edge[i] <= jj) k = i;
    end
    if (k < 0) return;
    d = mel_edge[k+1] - mel_edge[k];
    if (k == NB && jj >= mel_edge[NB+1]) begin
      // only a bin sitting on coinciding outer edges still counts, fully to the top band
      if (jj != mel_edge[NB]) return;
      w = '0;
    end else begin
      w = (d == 0) ? '0 : ((jj - mel_edge[k]) * UNITY_Q16 + d / 2) / d;
    end
    if (k < NB) add_capped(k, weighted(p, w));
    if (k >= 1) add_capped(k - 1, weighted(p, UNITY_Q16 - w));
  endfunction

  // fold one accepted bin into the model, queueing the frame's bands on a last bin
  function automatic void take_bin(logic [POWER_W-1:0] power, bit last, bit all_zero);
    band_beat_t beat;
    spread_bin(wide_t'(power) & POWER_MASK, bin_pos);
    if (bin_pos < BIN_CAP) bin_pos++;
    if (!last) return;
    for (int i = 0; i < NB; i++) begin
      beat.energy    = all_zero ? '0 : band_sum[i][ACC_W-1:0];
      beat.band      = BAND_IDX_W'(i);
      beat.last_band = (i == NB - 1);
      band_q.push_back(beat);
      band_sum[i] = '0;
    end
    bin_pos = 0;
  endfunction

  // ----------------------------------------------------------------- stimulus

  function automatic logic [POWER_W-1:0] pick_power();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return POWER_W'($urandom_range(255));
      default: return POWER_W'($urandom);
    endcase
  endfunction

  // random idle cycles, then hold the beat until the block takes it
  task automatic send_bin(logic [POWER_W-1:0] power, bit last, bit all_zero);
    while (!quiet && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= power;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    take_bin(power, last, all_zero);
    bins_sent++;
  endtask

  // hold off the bin stream until every owed band has come back
  task automatic drain_bands();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (band_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned frame_len;
    derive_edges();
    for (int i = 0; i < NB; i++) band_sum[i] = '0;
    bin_pos = 0;

    opening_bins = '{
      // one-bin frames below the lowest edge: every band reads zero
      '{32'hFFFF_FFFF, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b1, 1'b1},
      // a frame climbing across the first edges with extreme powers
      '{32'h0000_0001, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_FFFF, 1'b0, 1'b0},
      '{32'hFFFF_0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0},
      // alternating bit patterns in a two-bin frame
      '{32'hAAAA_AAAA, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b1, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_bins[i])
      send_bin(opening_bins[i].power, opening_bins[i].last, opening_bins[i].all_zero);
    drain_bands();

    // random frames: mostly short ones, the rest long, some of them past the top edge
    random_start = bins_sent;
    while (bins_sent - random_start < RANDOM_BINS) begin
      frame_len = ($urandom_range(9) < 6) ? $urandom_range(1, 40) : $urandom_range(180, 260);
      // the final frame is cut short to keep the bin budget
      if (frame_len > RANDOM_BINS - (bins_sent - random_start))
        frame_len = RANDOM_BINS - (bins_sent - random_start);
      for (int n = 0; n < frame_len; n++) begin
        quiet = (bins_sent - random_start >= 120) && (bins_sent - random_start < 300);
        send_bin(pick_power(), n == frame_len - 1, 1'b0);
      end
      if ($urandom_range(3) == 0) drain_bands();
    end
    quiet = 1'b0;

    drain_bands();
    repeat (2 * NB + 16) @(posedge clk);
    if (mismatches == 0 && band_q.size() == 0) begin
      $display("tb_mel_filterbank_accumulator: clean");
    end else begin
      $display("tb_mel_filterbank_accumulator: errors");
    end
    $finish;
  end

  // ------------------------------------------------------------------ checking

  always @(posedge clk) begin : band_check
    band_beat_t want;
    m_tready <= quiet || ($urandom_range(99) >= 16);
    if (m_tvalid && m_tready) begin
      if (band_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("band beat with none owed: energy %0d band %0d last %0b",
                   m_tdata, m_tuser, m_tlast);
      end else begin
        want = band_q.pop_front();
        if (m_tdata !== want.energy || m_tuser !== want.band || m_tlast !== want.last_band)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("band beat mismatch: want energy %0d band %0d last %0b, got %0d %0d %0b",
                     want.energy, want.band, want.last_band, m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no beat taken on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb_mel_filterbank_accumulator: errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/mfb_pkg.sv
hdl/mfb_acc_bank.sv
hdl/mel_filterbank_accumulator.sv
verif/tb_mel_filterbank_accumulator.sv
